// File: rtl/core/spi_qn_pkg.sv
// Package for the SPI master with quad nibble transfers.
// Holds field widths, register and request codes, and shared struct types.
// No dependencies.
package spi_qn_pkg;

    // Item fields
    localparam int TX_W      = 16;
    localparam int RX_W      = 16;
    localparam int SIO_W     = 4;
    localparam int REQ_W     = 2;

    // Configuration register fields
    localparam int MODE_W    = 2;
    localparam int WBITS_W   = 5;
    localparam int HPER_W    = 16;

    // Longest standard transfer in bits
    localparam int MAX_WORD_BITS = 16;

    // Default serial clock divider width
    localparam int DIVIDER_WIDTH_DEF = 16;

    // APB port
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_WBITS = 2'd1;
    localparam logic [1:0] REG_HPER  = 2'd2;

    // Request kinds
    localparam logic [REQ_W-1:0] OP_STD  = 2'd0;
    localparam logic [REQ_W-1:0] OP_QRD  = 2'd1;
    localparam logic [REQ_W-1:0] OP_QWR  = 2'd2;
    localparam logic [REQ_W-1:0] OP_NONE = 2'd3;

    // Reset values of the registers
    localparam logic [MODE_W-1:0]  MODE_RST  = 2'd0;
    localparam logic [WBITS_W-1:0] WBITS_RST = 5'd8;
    localparam logic [HPER_W-1:0]  HPER_RST  = 16'd50;

    typedef struct packed {
        logic [MODE_W-1:0]  spi_mode;
        logic [WBITS_W-1:0] word_bits;
        logic [HPER_W-1:0]  half_period_ticks;
    } t_cfg;

    // Mode write strobe with the new idle polarity
    typedef struct packed {
        logic wr;
        logic pol;
    } t_mode_upd;

    typedef struct packed {
        logic             sclk;
        logic [SIO_W-1:0] sio_out;
        logic [SIO_W-1:0] sio_oe;
        logic             busy_res;
        logic             done_res;
        logic [RX_W-1:0]  rx_data;
    } t_result;

endpackage

// File: rtl/core/spi_qn_if.sv
// Valid/ready channel interfaces for the SPI quad nibble master.
// Depends on spi_qn_pkg.
interface spi_qn_req_if;
    logic                          valid;
    logic                          ready;
    logic                          start_req;
    logic [spi_qn_pkg::REQ_W-1:0]  req_type;
    logic [spi_qn_pkg::TX_W-1:0]   tx_data;
    logic [spi_qn_pkg::SIO_W-1:0]  sio_in;

    modport source (output valid, start_req, req_type, tx_data, sio_in, input ready);
    modport sink   (input valid, start_req, req_type, tx_data, sio_in, output ready);
endinterface

interface spi_qn_res_if;
    logic                          valid;
    logic                          ready;
    logic                          sclk;
    logic [spi_qn_pkg::SIO_W-1:0]  sio_out;
    logic [spi_qn_pkg::SIO_W-1:0]  sio_oe;
    logic                          busy_res;
    logic                          done_res;
    logic [spi_qn_pkg::RX_W-1:0]   rx_data;

    modport source (output valid, sclk, sio_out, sio_oe, busy_res, done_res, rx_data,
                    input ready);
    modport sink   (input valid, sclk, sio_out, sio_oe, busy_res, done_res, rx_data,
                    output ready);
endinterface

// File: rtl/core/spi_qn_regs.sv
// APB configuration registers: mode, word size, half period.
// Depends on spi_qn_pkg.
module spi_qn_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [spi_qn_pkg::ADDR_W-1:0]  paddr,
    input  logic [spi_qn_pkg::DATA_W-1:0]  pwdata,
    output logic [spi_qn_pkg::DATA_W-1:0]  prdata,
    output logic                           pready,
    output spi_qn_pkg::t_cfg               o_cfg,
    output spi_qn_pkg::t_mode_upd          o_mode_upd
);
    import spi_qn_pkg::*;

    logic              w_wr;
    logic [1:0]        w_idx;
    logic [MODE_W-1:0]  r_mode;
    logic [WBITS_W-1:0] r_wbits;
    logic [HPER_W-1:0]  r_hper;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_RST;
            r_wbits <= WBITS_RST;
            r_hper  <= HPER_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_MODE:  r_mode  <= pwdata[MODE_W-1:0];
                REG_WBITS: r_wbits <= pwdata[WBITS_W-1:0];
                REG_HPER:  r_hper  <= pwdata[HPER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_MODE:  prdata = DATA_W'(r_mode);
            REG_WBITS: prdata = DATA_W'(r_wbits);
            REG_HPER:  prdata = DATA_W'(r_hper);
            default:   prdata = '0;
        endcase
    end

    assign o_cfg.spi_mode          = r_mode;
    assign o_cfg.word_bits         = r_wbits;
    assign o_cfg.half_period_ticks = r_hper;

    assign o_mode_upd.wr  = w_wr && (w_idx == REG_MODE);
    assign o_mode_upd.pol = pwdata[1];

endmodule

// File: rtl/core/spi_qn_obuf.sv
// Two-entry result buffer: output register plus skid register.
// Depends on spi_qn_pkg and spi_qn_if.
module spi_qn_obuf (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  spi_qn_pkg::t_result  i_data,
    output logic                 o_can_push,
    spi_qn_res_if.source         o_res
);
    import spi_qn_pkg::*;

    logic    r_main_vld;
    logic    r_skid_vld;
    t_result r_main;
    t_result r_skid;
    logic    w_pop;

    assign w_pop      = r_main_vld && o_res.ready;
    assign o_can_push = !r_skid_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_vld <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            // skid full: no push possible, drain into the main register
            if (w_pop) begin
                r_skid_vld <= 1'b0;
            end
        end else if (i_push && (!r_main_vld || w_pop)) begin
            r_main_vld <= 1'b1;
        end else if (i_push) begin
            r_skid_vld <= 1'b1;
        end else if (w_pop) begin
            r_main_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (w_pop) begin
                r_main <= r_skid;
            end
        end else if (i_push && (!r_main_vld || w_pop)) begin
            r_main <= i_data;
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

    assign o_res.valid    = r_main_vld;
    assign o_res.sclk     = r_main.sclk;
    assign o_res.sio_out  = r_main.sio_out;
    assign o_res.sio_oe   = r_main.sio_oe;
    assign o_res.busy_res = r_main.busy_res;
    assign o_res.done_res = r_main.done_res;
    assign o_res.rx_data  = r_main.rx_data;

endmodule

// File: rtl/core/spi_qn_step.sv
// Input register, transfer state and one-tick step logic of the SPI engine.
// Depends on spi_qn_pkg and spi_qn_if.
module spi_qn_step #(
    parameter int DIVIDER_WIDTH = spi_qn_pkg::DIVIDER_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    spi_qn_req_if.sink             i_req,
    input  spi_qn_pkg::t_cfg       i_cfg,
    input  spi_qn_pkg::t_mode_upd  i_mode_upd,
    input  logic                   i_can_push,
    output logic                   o_push,
    output spi_qn_pkg::t_result    o_data
);
    import spi_qn_pkg::*;

    localparam int RW = (DIVIDER_WIDTH > HPER_W) ? DIVIDER_WIDTH : HPER_W;

    // input register
    logic               r_in_vld;
    logic               r_start;
    logic [REQ_W-1:0]   r_rtype;
    logic [TX_W-1:0]    r_tx;
    logic [SIO_W-1:0]   r_sio;

    // transfer state
    logic                     r_busy,  n_busy;
    logic [REQ_W-1:0]         r_op,    n_op;
    logic [WBITS_W-1:0]       r_bl,    n_bl;
    logic                     r_sh,    n_sh;
    logic [DIVIDER_WIDTH-1:0] r_div,   n_div;
    logic [TX_W-1:0]          r_txs,   n_txs;
    logic [RX_W-1:0]          r_rxs,   n_rxs;
    logic                     r_clk,   n_clk;

    logic                     w_adv;
    logic [HPER_W-1:0]        w_h1;
    logic [RW-1:0]            w_hx;
    logic [RW-1:0]            w_dmax;
    logic [DIVIDER_WIDTH-1:0] w_reload;
    logic [WBITS_W-1:0]       w_nbits;
    logic [TX_W-1:0]          w_mask;
    logic [WBITS_W-1:0]       w_idx;
    logic                     w_sample;
    t_result                  w_res;

    assign w_adv       = r_in_vld && i_can_push;
    assign i_req.ready = !r_in_vld || w_adv;
    assign o_push      = w_adv;
    assign o_data      = w_res;

    // divider reload: zero acts as one, saturate at the counter's maximum
    always_comb begin
        w_h1     = (i_cfg.half_period_ticks == '0) ? '0 : i_cfg.half_period_ticks - 1'b1;
        w_hx     = RW'(w_h1);
        w_dmax   = RW'({DIVIDER_WIDTH{1'b1}});
        w_reload = (w_hx > w_dmax) ? w_dmax[DIVIDER_WIDTH-1:0] : w_hx[DIVIDER_WIDTH-1:0];
    end

    // effective word size, clamped to 1..MAX_WORD_BITS
    always_comb begin
        if (i_cfg.word_bits == '0) begin
            w_nbits = WBITS_W'(1);
        end else if ({1'b0, i_cfg.word_bits} > (WBITS_W+1)'(MAX_WORD_BITS)) begin
            w_nbits = WBITS_W'(MAX_WORD_BITS);
        end else begin
            w_nbits = i_cfg.word_bits;
        end
        w_mask = ~({TX_W{1'b1}} << w_nbits);
    end

    always_comb begin
        n_busy   = r_busy;
        n_op     = r_op;
        n_bl     = r_bl;
        n_sh     = r_sh;
        n_div    = r_div;
        n_txs    = r_txs;
        n_rxs    = r_rxs;
        n_clk    = r_clk;
        w_sample = 1'b0;
        w_res    = '0;

        if (!r_busy) begin
            if (r_start && (r_rtype != OP_NONE)) begin
                n_busy = 1'b1;
                n_op   = r_rtype;
                n_sh   = 1'b0;
                n_div  = w_reload;
                n_rxs  = '0;
                if (r_rtype == OP_STD) begin
                    n_txs = r_tx & w_mask;
                    n_bl  = w_nbits;
                end else begin
                    n_txs = {8'h00, r_tx[7:0]};
                    n_bl  = WBITS_W'(2);
                end
            end
        end else if (r_div != '0) begin
            n_div = r_div - 1'b1;
        end else if (!r_sh) begin
            // leading edge
            w_sample = (r_op == OP_QRD) || ((r_op == OP_STD) && !i_cfg.spi_mode[0]);
            n_clk    = !r_clk;
            n_sh     = 1'b1;
            n_div    = w_reload;
        end else begin
            // trailing edge
            w_sample = (r_op == OP_STD) && i_cfg.spi_mode[0];
            n_clk    = !r_clk;
            n_sh     = 1'b0;
            if (r_bl != '0) begin
                n_bl = r_bl - 1'b1;
            end
            if (n_bl == '0) begin
                n_busy         = 1'b0;
                w_res.done_res = 1'b1;
                n_clk          = i_cfg.spi_mode[1];
            end else begin
                n_div = w_reload;
            end
        end

        if (w_sample) begin
            if (r_op == OP_STD) begin
                n_rxs = {r_rxs[RX_W-2:0], r_sio[1]};
            end else begin
                n_rxs = {r_rxs[RX_W-5:0], r_sio};
            end
        end

        if (w_res.done_res && (r_op != OP_QWR)) begin
            w_res.rx_data = n_rxs;
        end

        // pin drive after this tick
        w_idx = n_bl - 1'b1;
        if (n_busy && (n_bl != '0)) begin
            if (n_op == OP_STD) begin
                w_res.sio_out = {3'b000, (w_idx[4] ? 1'b0 : n_txs[w_idx[3:0]])};
                w_res.sio_oe  = 4'h1;
            end else if (n_op == OP_QWR) begin
                w_res.sio_out = w_idx[0] ? n_txs[7:4] : n_txs[3:0];
                w_res.sio_oe  = 4'hF;
            end
        end

        w_res.sclk     = n_clk;
        w_res.busy_res = n_busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_req.ready) begin
            r_in_vld <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_start <= i_req.start_req;
            r_rtype <= i_req.req_type;
            r_tx    <= i_req.tx_data;
            r_sio   <= i_req.sio_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_op   <= OP_STD;
            r_bl   <= '0;
            r_sh   <= 1'b0;
            r_div  <= '0;
            r_txs  <= '0;
            r_rxs  <= '0;
            r_clk  <= 1'b0;
        end else begin
            if (w_adv) begin
                r_busy <= n_busy;
                r_op   <= n_op;
                r_bl   <= n_bl;
                r_sh   <= n_sh;
                r_div  <= n_div;
                r_txs  <= n_txs;
                r_rxs  <= n_rxs;
            end
            // a mode write while idle moves the clock to the new idle level
            if (i_mode_upd.wr && !r_busy) begin
                r_clk <= i_mode_upd.pol;
            end else if (w_adv) begin
                r_clk <= n_clk;
            end
        end
    end

endmodule

// File: rtl/core/spi_master_with_quad_nibble.sv
// Top level of the SPI master with standard and quad nibble transfers.
// Depends on spi_qn_pkg, spi_qn_if, spi_qn_regs, spi_qn_step, spi_qn_obuf.
//
//  Channel   Dir  Handshake        Carries
//  -------   ---  ---------------  ------------------------------------------
//  i_req     in   valid/ready      start_req, req_type, tx_data, sio_in
//  o_res     out  valid/ready      sclk, sio_out, sio_oe, busy_res, done_res,
//                                  rx_data
//  APB       in   psel/penable     spi_mode @0x0, word_bits @0x4,
//                                  half_period_ticks @0x8
//
// Each item is one tick of the pin-level engine: it is taken into an input
// register, stepped through the transfer state and its result lands in a
// two-entry output buffer. One item per cycle while the skid entry is free;
// an item waits in the input register until the buffer can take its result.
// Reset (i_rst_n low, synchronous) empties the input register and both buffer
// entries and returns the engine to idle with the clock low. When the sink
// stalls the skid entry absorbs one result and the input register holds one
// more item, then i_req.ready drops until the sink takes a result.
module spi_master_with_quad_nibble #(
    parameter int DIVIDER_WIDTH = spi_qn_pkg::DIVIDER_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    spi_qn_req_if.sink                     i_req,
    spi_qn_res_if.source                   o_res,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [spi_qn_pkg::ADDR_W-1:0]  paddr,
    input  logic [spi_qn_pkg::DATA_W-1:0]  pwdata,
    output logic [spi_qn_pkg::DATA_W-1:0]  prdata,
    output logic                           pready
);
    import spi_qn_pkg::*;

    t_cfg      w_cfg;
    t_mode_upd w_mode_upd;
    logic      w_can_push;
    logic      w_push;
    t_result   w_data;

    // Register file; mode writes also retarget the idle clock level
    spi_qn_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_cfg      (w_cfg),
        .o_mode_upd (w_mode_upd)
    );

    // Engine: divider, edge sequencing, shift registers
    spi_qn_step #(
        .DIVIDER_WIDTH (DIVIDER_WIDTH)
    ) u_step (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .i_cfg      (w_cfg),
        .i_mode_upd (w_mode_upd),
        .i_can_push (w_can_push),
        .o_push     (w_push),
        .o_data     (w_data)
    );

    // Result buffer decouples the sink's ready from the input side
    spi_qn_obuf u_obuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_data     (w_data),
        .o_can_push (w_can_push),
        .o_res      (o_res)
    );

endmodule

// File: tb/tb_spi_master_with_quad_nibble.sv
// Self-checking testbench for spi_master_with_quad_nibble: drives one engine tick per
// request item and compares every result item against a cycle-exact predictor.
// Depends on spi_qn_pkg, spi_qn_req_if/spi_qn_res_if and the RTL top level.
`timescale 1ns / 100ps

module tb_spi_master_with_quad_nibble;
    import spi_qn_pkg::*;

    localparam int         WATCHDOG_LIMIT = 2000;
    // The register map has one unused slot at the top of paddr[3:2].
    localparam logic [1:0] REG_SPARE      = 2'd3;

    // Predictor of the pin-level engine: one call of take_tick per accepted
    // request item, one expected pin snapshot queued per call.
    class spi_pin_predictor;
        logic [MODE_W-1:0]  mode;
        logic [WBITS_W-1:0] wbits;
        logic [HPER_W-1:0]  hper;

        logic        busy;
        logic [1:0]  kind;
        logic [4:0]  bits_left;
        logic        second_half;
        logic [15:0] div_cnt;
        logic [15:0] tx_sh;
        logic [15:0] rx_sh;
        logic        clk_lvl;

        t_result     pin_levels_q[$];
        int          errors;

        function new();
            mode        = MODE_RST;
            wbits       = WBITS_RST;
            hper        = HPER_RST;
            busy        = 1'b0;
            kind        = OP_STD;
            bits_left   = '0;
            second_half = 1'b0;
            div_cnt     = '0;
            tx_sh       = '0;
            rx_sh       = '0;
            clk_lvl     = 1'b0;
            errors      = 0;
        endfunction

        function int pending();
            return pin_levels_q.size();
        endfunction

        function logic [15:0] reload();
            return (hper == '0) ? 16'd0 : hper - 16'd1;
        endfunction

        function logic [4:0] word_len();
            if (wbits == '0) return 5'd1;
            if (wbits > MAX_WORD_BITS) return 5'(MAX_WORD_BITS);
            return wbits;
        endfunction

        function void sample(logic [3:0] sio);
            if (kind == OP_STD) rx_sh = {rx_sh[14:0], sio[1]};
            else                rx_sh = {rx_sh[11:0], sio};
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_MODE: begin
                    mode = value[MODE_W-1:0];
                    // An idle clock follows the new polarity at once.
                    if (!busy) clk_lvl = mode[1];
                end
                REG_WBITS: wbits = value[WBITS_W-1:0];
                REG_HPER:  hper  = value[HPER_W-1:0];
                default: ;
            endcase
        endfunction

        function void take_tick(logic start, logic [1:0] rt, logic [15:0] tx, logic [3:0] sio);
            t_result     res;
            logic [31:0] mask;
            logic [4:0]  n;
            logic        phase;
            phase = mode[0];
            res   = '0;
            if (!busy) begin
                if (start && rt != OP_NONE) begin
                    busy        = 1'b1;
                    kind        = rt;
                    second_half = 1'b0;
                    div_cnt     = reload();
                    rx_sh       = '0;
                    if (rt == OP_STD) begin
                        n         = word_len();
                        mask      = (32'd1 << n) - 32'd1;
                        tx_sh     = tx & mask[15:0];
                        bits_left = n;
                    end else begin
                        tx_sh     = {8'h00, tx[7:0]};
                        bits_left = 5'd2;
                    end
                end
            end else if (div_cnt != '0) begin
                div_cnt = div_cnt - 16'd1;
            end else if (!second_half) begin
                // Leading edge
                if (kind == OP_QRD || (kind == OP_STD && !phase)) sample(sio);
                clk_lvl     = ~clk_lvl;
                second_half = 1'b1;
                div_cnt     = reload();
            end else begin
                // Trailing edge
                if (kind == OP_STD && phase) sample(sio);
                clk_lvl     = ~clk_lvl;
                second_half = 1'b0;
                if (bits_left != '0) bits_left = bits_left - 5'd1;
                if (bits_left == '0) begin
                    busy         = 1'b0;
                    res.done_res = 1'b1;
                    if (kind != OP_QWR) res.rx_data = rx_sh;
                    clk_lvl      = mode[1];
                end else begin
                    div_cnt = reload();
                end
            end

            if (busy && bits_left != '0) begin
                if (kind == OP_STD) begin
                    res.sio_out = {3'b000, tx_sh[bits_left - 5'd1]};
                    res.sio_oe  = 4'h1;
                end else if (kind == OP_QWR) begin
                    // Two slots left means the high nibble is on the pins.
                    res.sio_out = bits_left[0] ? tx_sh[3:0] : tx_sh[7:4];
                    res.sio_oe  = 4'hF;
                end
            end
            res.sclk     = clk_lvl;
            res.busy_res = busy;
            pin_levels_q.push_back(res);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("%0t MISMATCH %s: got %h want %h", $realtime, what, got, want);
            errors++;
        endtask

        task check_pins(t_result got);
            t_result want;
            if (pin_levels_q.size() == 0) begin
                report("result with nothing expected", 32'(got.rx_data), 0);
                return;
            end
            want = pin_levels_q.pop_front();
            if (got.sclk     !== want.sclk)
                report("sclk", 32'(got.sclk), 32'(want.sclk));
            if (got.sio_out  !== want.sio_out)
                report("sio_out", 32'(got.sio_out), 32'(want.sio_out));
            if (got.sio_oe   !== want.sio_oe)
                report("sio_oe", 32'(got.sio_oe), 32'(want.sio_oe));
            if (got.busy_res !== want.busy_res)
                report("busy_res", 32'(got.busy_res), 32'(want.busy_res));
            if (got.done_res !== want.done_res)
                report("done_res", 32'(got.done_res), 32'(want.done_res));
            if (got.rx_data  !== want.rx_data)
                report("rx_data", 32'(got.rx_data), 32'(want.rx_data));
        endtask
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    spi_qn_req_if req_ch();
    spi_qn_res_if res_ch();

    spi_master_with_quad_nibble uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    spi_pin_predictor pins = new();

    // Idle percentages of the request side and the result side.
    int src_idle_pct;
    int snk_idle_pct;
    int quiet_cycles;

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    // Result side: stall at random, decided once per cycle on the falling edge.
    always @(negedge i_clk) begin
        res_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // Sample both channels at the rising edge; feed the predictor and the checker.
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                got.sclk     = res_ch.sclk;
                got.sio_out  = res_ch.sio_out;
                got.sio_oe   = res_ch.sio_oe;
                got.busy_res = res_ch.busy_res;
                got.done_res = res_ch.done_res;
                got.rx_data  = res_ch.rx_data;
                pins.check_pins(got);
            end
            if (req_ch.valid && req_ch.ready)
                pins.take_tick(req_ch.start_req, req_ch.req_type, req_ch.tx_data,
                               req_ch.sio_in);
            // Watchdog: count cycles in which neither channel moves an item.
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Offer one engine tick. Enter and leave on a falling edge; leave valid high
    // so back-to-back items need no second assignment in one step.
    task automatic send_tick(logic start, logic [1:0] rt, logic [15:0] tx, logic [3:0] sio);
        while ($urandom_range(99) < src_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.start_req <= start;
        req_ch.req_type  <= rt;
        req_ch.tx_data   <= tx;
        req_ch.sio_in    <= sio;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // A tick with random content; start strobes here only matter while idle.
    task automatic noise_tick(int start_pct);
        send_tick($urandom_range(99) < start_pct, 2'($urandom_range(3)), 16'($urandom),
                  4'($urandom));
    endtask

    // Drop valid and hold until every expected result has come out.
    task automatic drain();
        req_ch.valid <= 1'b0;
        do @(negedge i_clk); while (pins.pending() != 0);
    endtask

    // APB write: setup cycle, access cycle, then the port is released.
    task automatic apb_write(logic [1:0] idx, logic [31:0] value);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        pins.write_reg(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_config(logic [1:0] mode, logic [4:0] wbits, logic [15:0] hper);
        apb_write(REG_MODE, 32'(mode));
        apb_write(REG_WBITS, 32'(wbits));
        apb_write(REG_HPER, 32'(hper));
    endtask

    // Advance the engine until the transfer in flight has ended.
    task automatic finish_transfer();
        while (pins.busy) noise_tick(50);
    endtask

    task automatic run_transfer(logic [1:0] rt, logic [15:0] tx);
        send_tick(1'b1, rt, tx, 4'($urandom));
        finish_transfer();
    endtask

    task automatic random_config();
        logic [4:0]  wbits;
        logic [15:0] hper;
        // Mostly legal word sizes, sometimes anything the field can hold.
        wbits = ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(1, 16));
        // Keep half periods short so transfers finish inside a chunk.
        hper  = ($urandom_range(9) == 0) ? 16'($urandom_range(4, 8))
                                         : 16'($urandom_range(0, 2));
        set_config(2'($urandom_range(3)), wbits, hper);
    endtask

    initial begin
        i_rst_n          = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.start_req = 1'b0;
        req_ch.req_type  = OP_STD;
        req_ch.tx_data   = '0;
        req_ch.sio_in    = '0;
        res_ch.ready     = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        src_idle_pct     = 0;
        snk_idle_pct     = 0;
        quiet_cycles     = 0;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: field extremes, every request kind, every mode.
        set_config(2'd0, 5'd16, 16'd1);
        run_transfer(OP_STD, 16'hFFFF);
        run_transfer(OP_STD, 16'h0000);
        apb_write(REG_MODE, 32'd1);
        run_transfer(OP_STD, 16'hA5A5);
        apb_write(REG_MODE, 32'd2);
        run_transfer(OP_STD, 16'h5A5A);
        apb_write(REG_MODE, 32'd3);
        run_transfer(OP_STD, 16'hFFFF);
        run_transfer(OP_QRD, 16'hFFFF);
        run_transfer(OP_QWR, 16'hFFA5);
        apb_write(REG_MODE, 32'd0);
        run_transfer(OP_QWR, 16'h00FF);
        // Unused request kind starts nothing.
        run_transfer(OP_NONE, 16'hFFFF);
        // Word size out of range clamps to one bit and to the widest word.
        apb_write(REG_WBITS, 32'd0);
        run_transfer(OP_STD, 16'hFFFF);
        apb_write(REG_WBITS, 32'd31);
        run_transfer(OP_STD, 16'hC3C3);
        apb_write(REG_WBITS, 32'd1);
        run_transfer(OP_STD, 16'h0001);
        // Zero half period acts as one tick.
        apb_write(REG_HPER, 32'd0);
        run_transfer(OP_QRD, 16'h0000);
        // Writes to the unused slot change nothing.
        apb_write(REG_SPARE, 32'hFFFF_FFFF);
        run_transfer(OP_QWR, 16'h3C3C);

        // Registers rewritten in the middle of a transfer.
        set_config(2'd0, 5'd16, 16'd6);
        send_tick(1'b1, OP_STD, 16'hBEEF, 4'($urandom));
        repeat (20) noise_tick(50);
        apb_write(REG_MODE, 32'd3);
        repeat (20) noise_tick(50);
        apb_write(REG_HPER, 32'd1);
        apb_write(REG_WBITS, 32'd4);
        finish_transfer();
        run_transfer(OP_STD, 16'hFFFF);

        // Random: three idle profiles, a fresh setting every chunk.
        for (int prof = 0; prof < 3; prof++) begin
            src_idle_pct = (prof == 0) ? 33 : (prof == 1) ? 64 : 0;
            snk_idle_pct = (prof == 0) ? 64 : (prof == 1) ? 33 : 0;
            for (int chunk = 0; chunk < 4; chunk++) begin
                random_config();
                repeat (120) noise_tick(25);
            end
        end

        // Long half period: start a two-bit word, then shorten the period
        // mid-transfer; the new count applies from the next reload.
        set_config(2'd2, 5'd2, 16'd40);
        send_tick(1'b1, OP_STD, 16'($urandom), 4'($urandom));
        repeat (50) noise_tick(50);
        apb_write(REG_HPER, 32'd2);
        finish_transfer();
        run_transfer(OP_QRD, 16'($urandom));

        drain();
        repeat (8) @(posedge i_clk);
        if (pins.pending() != 0)
            pins.report("expectations left over", 32'(pins.pending()), 0);
        if (pins.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
